// File: rtl/cdq_pkg.sv
// Shared constants, codes and types for the circular deque.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

    // Fixed field widths
    localparam int CMD_W = 2;
    localparam int ST_W  = 2;
    localparam int CFG_W = 5;
    localparam int OCC_W = 5;

    // Parameter defaults
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 2'd3;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

    // Per-cell operation broadcast along the chain
    typedef logic [2:0] t_cell_op;

    localparam t_cell_op CELL_HOLD = 3'd0;
    localparam t_cell_op CELL_CLR  = 3'd1;  // drop all entries
    localparam t_cell_op CELL_SHR  = 3'd2;  // shift toward rear, new front
    localparam t_cell_op CELL_SHL  = 3'd3;  // shift toward front, drop front
    localparam t_cell_op CELL_INS  = 3'd4;  // append behind the rear entry
    localparam t_cell_op CELL_DEL  = 3'd5;  // drop the rear entry

endpackage

`default_nettype wire

// File: rtl/cdq_ifs.sv
// Valid/ready channel interfaces for the command and result transactions.
`timescale 1ns / 1ps
`default_nettype none

interface cdq_cmd_if
    import cdq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic [CMD_W-1:0]             cmd;
    logic signed [DATA_WIDTH-1:0] push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface cdq_res_if
    import cdq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic [ST_W-1:0]              status;
    logic signed [DATA_WIDTH-1:0] popped_value;
    logic [OCC_W-1:0]             occupancy;

    modport source (output valid, output status, output popped_value, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input popped_value, input occupancy,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/cdq_cell.sv
// One deque slot: a data register and a valid bit, linked to both neighbors.
`timescale 1ns / 1ps
`default_nettype none

module cdq_cell
    import cdq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cell_op              i_op,
    input  wire logic [DATA_WIDTH-1:0] i_push_data,
    input  wire logic [DATA_WIDTH-1:0] i_left_data,
    input  wire logic                  i_left_valid,
    input  wire logic [DATA_WIDTH-1:0] i_right_data,
    input  wire logic                  i_right_valid,
    output logic      [DATA_WIDTH-1:0] o_data,
    output logic                       o_valid,
    output logic      [DATA_WIDTH-1:0] o_tail_data
);

    logic                  r_valid;
    logic                  n_valid;
    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        unique case (i_op)
            CELL_HOLD: begin
            end
            CELL_CLR: begin
                n_valid = 1'b0;
            end
            CELL_SHR: begin
                n_valid = i_left_valid;
                n_data  = i_left_data;
            end
            CELL_SHL: begin
                n_valid = i_right_valid;
                n_data  = i_right_data;
            end
            CELL_INS: begin
                // first free slot: left neighbor full, this one empty
                if (!r_valid && i_left_valid) begin
                    n_valid = 1'b1;
                    n_data  = i_push_data;
                end
            end
            CELL_DEL: begin
                if (r_valid && !i_right_valid) begin
                    n_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data      = r_data;
    assign o_valid     = r_valid;
    // Only the rear entry drives the shared OR bus
    assign o_tail_data = (r_valid && !i_right_valid) ? r_data : '0;

endmodule

`default_nettype wire

// File: rtl/circular_deque.sv
// Top level of the circular deque: command decode, cell chain, result register.
//
//  channel   | dir | handshake         | payload
//  ----------+-----+-------------------+------------------------------------
//  i_cmd     | in  | valid/ready       | cmd, push_value
//  o_res     | out | valid/ready       | status, popped_value, occupancy
//  i_cfg_*   | in  | write enable only | active_size (5 bits)
//
//  One command per clock while o_res is not stalled: the cell chain shifts,
//  inserts or drops, and the result lands in an output register in the cycle
//  after accept. i_cmd.ready is high whenever that register is empty or being
//  drained, so a stalled result holds the input off by exactly that one slot.
//  Reset (synchronous, active low) empties the deque and sets the capacity to
//  DEPTH. A capacity write also empties the deque; slot data is kept.
`timescale 1ns / 1ps
`default_nettype none

module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    cdq_cmd_if.sink               i_cmd,
    cdq_res_if.source             o_res
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Deque state: capacity and occupancy
    logic [CNT_W-1:0] r_cap;
    logic [CNT_W-1:0] n_cap;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // Result register
    logic                  r_out_valid;
    logic [ST_W-1:0]       r_out_status;
    logic [ST_W-1:0]       n_out_status;
    logic [DATA_WIDTH-1:0] r_out_popped;
    logic [DATA_WIDTH-1:0] n_out_popped;

    // Cell chain nets
    logic [DATA_WIDTH-1:0] w_data      [DEPTH];
    logic [DATA_WIDTH-1:0] w_tail_data [DEPTH];
    logic [DEPTH-1:0]      w_valid;
    logic [DATA_WIDTH-1:0] w_tail_or;
    t_cell_op              w_op;

    logic w_accept;
    logic w_full;
    logic w_empty;

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_full      = (r_count >= r_cap);
    assign w_empty     = (r_count == '0);

    // Saturate the written capacity into 1..DEPTH
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_cap = CNT_W'(1);
        end else if (int'(i_cfg_wdata) > DEPTH) begin
            n_cap = CNT_W'(DEPTH);
        end else begin
            n_cap = CNT_W'(i_cfg_wdata);
        end
    end

    // rear entry: one-hot OR of the cells' gated outputs
    always_comb begin
        w_tail_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_tail_or = w_tail_or | w_tail_data[i];
        end
    end

    // Command decode
    always_comb begin
        w_op         = CELL_HOLD;
        n_count      = r_count;
        n_out_status = ST_OK;
        n_out_popped = '0;
        if (i_cfg_we) begin
            w_op    = CELL_CLR;
            n_count = '0;
        end else if (w_accept) begin
            unique case (i_cmd.cmd)
                CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                    if (w_full) begin
                        n_out_status = ST_OVERFLOW;
                    end else begin
                        w_op    = (i_cmd.cmd == CMD_PUSH_FRONT) ? CELL_SHR : CELL_INS;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                CMD_POP_FRONT: begin
                    if (w_empty) begin
                        n_out_status = ST_UNDERFLOW;
                    end else begin
                        w_op         = CELL_SHL;
                        n_count      = r_count - CNT_W'(1);
                        n_out_popped = w_data[0];
                    end
                end
                CMD_POP_REAR: begin
                    if (w_empty) begin
                        n_out_status = ST_UNDERFLOW;
                    end else begin
                        w_op         = CELL_DEL;
                        n_count      = r_count - CNT_W'(1);
                        n_out_popped = w_tail_or;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Chain of cells; cell 0 holds the front entry
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left_data;
        logic                  w_left_valid;
        logic [DATA_WIDTH-1:0] w_right_data;
        logic                  w_right_valid;

        if (g == 0) begin : g_first
            assign w_left_data  = i_cmd.push_value;
            assign w_left_valid = 1'b1;
        end else begin : g_mid_l
            assign w_left_data  = w_data[g-1];
            assign w_left_valid = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right_data  = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_mid_r
            assign w_right_data  = w_data[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        cdq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_op          (w_op),
            .i_push_data   (i_cmd.push_value),
            .i_left_data   (w_left_data),
            .i_left_valid  (w_left_valid),
            .i_right_data  (w_right_data),
            .i_right_valid (w_right_valid),
            .o_data        (w_data[g]),
            .o_valid       (w_valid[g]),
            .o_tail_data   (w_tail_data[g])
        );
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CNT_W'(DEPTH);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= n_cap;
            end
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_status <= n_out_status;
            r_out_popped <= n_out_popped;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out_status;
    assign o_res.popped_value = r_out_popped;
    assign o_res.occupancy    = OCC_W'(r_count);

`ifndef SYNTHESIS
    // Occupied cells form a solid run from the front
    a_valid_thermo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + DEPTH'(1))) == '0)
        else $error("cell valid bits not contiguous from the front");

    // Count tracks the number of occupied cells
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("occupancy count disagrees with cell chain");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("occupancy above capacity");

    // A rejected push leaves the cell valid bits unchanged and reports overflow
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_cfg_we && w_full &&
         (i_cmd.cmd == CMD_PUSH_FRONT || i_cmd.cmd == CMD_PUSH_REAR))
        |=> (r_out_status == ST_OVERFLOW) && $stable(w_valid))
        else $error("push when full did not report overflow");
`endif

endmodule

`default_nettype wire
